// ----- hw/rtl/playfair_digram_encrypt_top_defines.svh -----
// Assertion helpers shared by the digram encryptor RTL.
`ifndef PLAYFAIR_DIGRAM_ENCRYPT_TOP_DEFINES_SVH
`define PLAYFAIR_DIGRAM_ENCRYPT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define PFE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pfe assertion failed");
// Check on every clock edge, reset included.
`define PFE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pfe assertion failed");
`else
`define PFE_ASSERT(lbl, prop)
`define PFE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hw/rtl/pfe_pkg.sv -----
package pfe_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned Side    = 5;
  localparam int unsigned RowW    = Side * LetterW;
  localparam int unsigned IdxW    = 3;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [RowW-1:0]    row_t;

  // Square indexed [row][col]; column 0 sits in the low bits of each row.
  typedef logic [Side-1:0][Side-1:0][LetterW-1:0] sq_t;

  localparam letter_t LetterX = letter_t'(23);
  localparam letter_t LetterI = letter_t'(8);
  localparam letter_t LetterJ = letter_t'(9);

  localparam idx_t NumRows = idx_t'(Side);
  localparam idx_t LastIdx = idx_t'(Side - 1);

  localparam row_t SquareRow0Rst = row_t'(4294688);
  localparam row_t SquareRow1Rst = row_t'(10755269);
  localparam row_t SquareRow2Rst = row_t'(16201099);
  localparam row_t SquareRow3Rst = row_t'(21613104);
  localparam row_t SquareRow4Rst = row_t'(27025109);

  typedef struct packed {
    idx_t row;
    idx_t col;
  } pos_t;

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    last;
    logic    twice;
  } digram_t;

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    last;
    logic    twice;
  } result_t;

  function automatic idx_t wrap_inc(idx_t v);
    return (v == LastIdx) ? '0 : idx_t'(v + idx_t'(1));
  endfunction

  // Last hit in row-major order; fall back to I (to J when the code is I), then to row 0 col 0.
  function automatic pos_t locate(sq_t sq, letter_t code);
    pos_t    p_main;
    pos_t    p_alt;
    logic    hit_main;
    logic    hit_alt;
    letter_t alt;
    alt      = (code == LetterI) ? LetterJ : LetterI;
    p_main   = '0;
    p_alt    = '0;
    hit_main = 1'b0;
    hit_alt  = 1'b0;
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        if (sq[r][c] == code) begin
          hit_main   = 1'b1;
          p_main.row = idx_t'(r);
          p_main.col = idx_t'(c);
        end
        if (sq[r][c] == alt) begin
          hit_alt   = 1'b1;
          p_alt.row = idx_t'(r);
          p_alt.col = idx_t'(c);
        end
      end
    end
    if (hit_main) begin
      return p_main;
    end else if (hit_alt) begin
      return p_alt;
    end
    return '0;
  endfunction

endpackage

// ----- hw/rtl/playfair_digram_encrypt_top.sv -----
// Playfair digram encryptor.
// Input channel: in_valid_i/in_ready_o move one plaintext letter (A=0..Z=25)
// with end_of_text_i flagging the last letter of a message. Letters are paired
// into digrams; a doubled letter is closed with X, an odd tail padded with X.
// Output channel: out_valid_o/out_ready_i move one cipher digram with
// end_of_output_o set on the final digram of the message.
// Configuration: cfg_we_i writes cfg_data_i into square row cfg_index_i (0..4)
// in the same cycle; write only while no request is in flight.
// A completed digram is held in the pairing register, encrypted combinationally
// and then held in the output register, which presents it to the receiver.
// Throughput: one letter per cycle while the output is not stalled, set by the
// pairing register and the output register each taking a request every cycle;
// a doubled final letter makes the output register present its digram twice.
// Reset: no letter pending, both stages empty, square loaded with the
// standard A..Z (no J) arrangement.
// Stall: the output register holds its digram until taken; the pairing
// register keeps accepting while the output register can drain, then holds.
module playfair_digram_encrypt_top import pfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  row_t       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  letter_t    letter_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output letter_t    cipher_first_o,
  output letter_t    cipher_second_o,
  output logic       end_of_output_o
);

  sq_t     square_q;
  logic    dg_valid;
  logic    dg_ready;
  digram_t dg;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_q[0] <= SquareRow0Rst;
      square_q[1] <= SquareRow1Rst;
      square_q[2] <= SquareRow2Rst;
      square_q[3] <= SquareRow3Rst;
      square_q[4] <= SquareRow4Rst;
    end else if (cfg_we_i && (cfg_index_i < NumRows)) begin
      square_q[cfg_index_i] <= cfg_data_i;
    end
  end

  pfe_pair u_pair (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .letter_i      (letter_i),
    .end_of_text_i (end_of_text_i),
    .dg_valid_o    (dg_valid),
    .dg_ready_i    (dg_ready),
    .dg_o          (dg)
  );

  pfe_encrypt u_encrypt (
    .sq_i  (square_q),
    .dg_i  (dg),
    .res_o (res)
  );

  pfe_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (dg_valid),
    .res_ready_o     (dg_ready),
    .res_i           (res),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cipher_first_o  (cipher_first_o),
    .cipher_second_o (cipher_second_o),
    .end_of_output_o (end_of_output_o)
  );

endmodule

// ----- hw/rtl/pfe_pair.sv -----
`include "playfair_digram_encrypt_top_defines.svh"

module pfe_pair import pfe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  letter_t letter_i,
  input  logic    end_of_text_i,
  output logic    dg_valid_o,
  input  logic    dg_ready_i,
  output digram_t dg_o
);

  logic    pend_valid_q, pend_valid_d;
  letter_t pend_letter_q, pend_letter_d;
  logic    dg_valid_q, dg_valid_d;
  digram_t dg_q, dg_d;
  logic    accept;
  logic    emit;

  assign in_ready_o = !dg_valid_q || dg_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    emit          = 1'b0;
    dg_d          = dg_q;
    if (accept) begin
      if (!pend_valid_q) begin
        if (end_of_text_i) begin
          emit = 1'b1;
          dg_d = '{first: letter_i, second: LetterX, last: 1'b1, twice: 1'b0};
        end else begin
          pend_valid_d  = 1'b1;
          pend_letter_d = letter_i;
        end
      end else if (pend_letter_q != letter_i) begin
        emit          = 1'b1;
        dg_d          = '{first: pend_letter_q, second: letter_i,
                          last: end_of_text_i, twice: 1'b0};
        pend_valid_d  = 1'b0;
        pend_letter_d = '0;
      end else begin
        // doubled letter: close with X; the repeat opens the next pair, or at end of text the digram is sent twice
        emit = 1'b1;
        dg_d = '{first: pend_letter_q, second: LetterX,
                 last: end_of_text_i, twice: end_of_text_i};
        if (end_of_text_i) begin
          pend_valid_d  = 1'b0;
          pend_letter_d = '0;
        end else begin
          pend_letter_d = letter_i;
        end
      end
    end
  end

  always_comb begin
    dg_valid_d = dg_valid_q;
    if (accept) begin
      dg_valid_d = emit;
    end else if (dg_ready_i) begin
      dg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      pend_letter_q <= '0;
      dg_valid_q    <= 1'b0;
    end else begin
      pend_valid_q  <= pend_valid_d;
      pend_letter_q <= pend_letter_d;
      dg_valid_q    <= dg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      dg_q <= dg_d;
    end
  end

  assign dg_valid_o = dg_valid_q;
  assign dg_o       = dg_q;

  `PFE_ASSERT(a_pend_drop_on_end, (accept && end_of_text_i) |=> !pend_valid_q)
  `PFE_ASSERT(a_stage_hold, (dg_valid_q && !dg_ready_i) |=> dg_valid_q)

endmodule

// ----- hw/rtl/pfe_encrypt.sv -----
module pfe_encrypt import pfe_pkg::*; (
  input  sq_t     sq_i,
  input  digram_t dg_i,
  output result_t res_o
);

  pos_t    pa;
  pos_t    pb;
  letter_t x;
  letter_t y;

  assign pa = locate(sq_i, dg_i.first);
  assign pb = locate(sq_i, dg_i.second);

  always_comb begin
    if (pa.row == pb.row) begin
      x = sq_i[pa.row][wrap_inc(pa.col)];
      y = sq_i[pb.row][wrap_inc(pb.col)];
    end else if (pa.col == pb.col) begin
      x = sq_i[wrap_inc(pa.row)][pa.col];
      y = sq_i[wrap_inc(pb.row)][pb.col];
    end else begin
      x = sq_i[pa.row][pb.col];
      y = sq_i[pb.row][pa.col];
    end
  end

  assign res_o = '{first: x, second: y, last: dg_i.last, twice: dg_i.twice};

endmodule

// ----- hw/rtl/pfe_out.sv -----
`include "playfair_digram_encrypt_top_defines.svh"

module pfe_out import pfe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  output logic    res_ready_o,
  input  result_t res_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output letter_t cipher_first_o,
  output letter_t cipher_second_o,
  output logic    end_of_output_o
);

  logic    out_valid_q, out_valid_d;
  logic    twice_q, twice_d;
  logic    end_q, end_d;
  letter_t first_q;
  letter_t second_q;
  logic    take;

  assign res_ready_o = !out_valid_q || (out_ready_i && !twice_q);
  assign take        = res_valid_i && res_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    twice_d     = twice_q;
    end_d       = end_q;
    if (take) begin
      out_valid_d = 1'b1;
      twice_d     = res_i.twice;
      end_d       = res_i.last && !res_i.twice;
    end else if (out_valid_q && out_ready_i) begin
      if (twice_q) begin
        // repeat the digram as the closing request
        twice_d = 1'b0;
        end_d   = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      twice_q     <= 1'b0;
      end_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      twice_q     <= twice_d;
      end_q       <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      first_q  <= res_i.first;
      second_q <= res_i.second;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_first_o  = first_q;
  assign cipher_second_o = second_q;
  assign end_of_output_o = end_q;

  `PFE_ASSERT_ALWAYS(a_twice_needs_valid, twice_q |-> out_valid_q)
  `PFE_ASSERT_ALWAYS(a_twice_not_end, twice_q |-> !end_q)
  `PFE_ASSERT(a_repeat_is_final, (out_valid_q && out_ready_i && twice_q) |=> (out_valid_q && end_q))

endmodule
